// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker file bsa_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, muted while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds across reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bsa_pkg.sv =====
package bsa_pkg;

   localparam int DEF_MAX_BLOCKS      = 16;
   localparam int DEF_SLOTS_PER_BLOCK = 256;

   localparam int BLK_FW  = 4;
   localparam int SLOT_FW = 8;
   localparam int REQ_W   = 16;
   localparam int RSP_W   = 16;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_OOM      = 2'd1,
      STAT_BAD_FREE = 2'd2,
      STAT_RSVD     = 2'd3
   } status_type;

   // request word, lowest field last
   typedef struct packed {
      logic [1:0]         pad;
      logic [SLOT_FW-1:0] slot_index;
      logic [BLK_FW-1:0]  blk_idx;
      op_type             op;
   } req_word_type;

   // response word, lowest field last
   typedef struct packed {
      logic               pad;
      logic               is_marked;
      status_type         status;
      logic [SLOT_FW-1:0] out_slot;
      logic [BLK_FW-1:0]  out_block;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic link_read;
      logic finish;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic need_link;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== sv/bsa_ctrl.sv =====
module bsa_ctrl import bsa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_EXEC  = 4'b0100,
      S_LINK  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            // a pop needs the link word before the tables can be written
            if (stat.need_link) begin
               cmd.link_read = 1'b1;
               state_in      = S_LINK;
            end else if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_LINK: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/bsa_datapath.sv =====
module bsa_datapath import bsa_pkg::*; #(
   parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS,
   parameter int SLOTS_PER_BLOCK = DEF_SLOTS_PER_BLOCK
) (
   input  logic             clock,
   input  logic             reset,
   input  ctl_cmd_type      cmd,
   output dp_stat_type      stat,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tready,
   output logic             rsp_tvalid,
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int BI_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int SI_W   = $clog2(SLOTS_PER_BLOCK);
   localparam int PTR_W  = $clog2(SLOTS_PER_BLOCK + 1);
   localparam int TOTAL  = MAX_BLOCKS * SLOTS_PER_BLOCK;
   localparam int ADDR_W = $clog2(TOTAL);

   typedef struct packed {
      logic [PTR_W-1:0] bump;
      logic [SI_W-1:0]  head;
      logic [PTR_W-1:0] count;
   } blk_entry_type;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [BI_W-1:0] blk,
                                                 input logic [31:0] slot);
      return ADDR_W'(32'(blk) * SLOTS_PER_BLOCK + slot);
   endfunction

   // storage
   blk_entry_type   tbl_mem  [MAX_BLOCKS];
   logic [SI_W-1:0] link_mem [TOTAL];
   logic            mark_mem [TOTAL];

   // control state
   logic [CNT_W-1:0]      open_ff, open_in;
   logic [MAX_BLOCKS-1:0] room_ff, room_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // per-item registers
   op_type              op_ff;
   logic [BLK_FW-1:0]   echo_blk_ff;
   logic [SLOT_FW-1:0]  echo_slot_ff;
   logic [BI_W-1:0]     blk_ff;
   logic                new_ff;
   logic                oom_ff;
   logic                ok_ff;
   logic [ADDR_W-1:0]   addr_ff;
   blk_entry_type       tbl_q_ff;
   logic                mark_q_ff;
   logic [SI_W-1:0]     link_q_ff;
   rsp_word_type        rsp_ff, rsp_in;

   // accept-side decode
   req_word_type    req;
   logic [BI_W-1:0] req_blk;
   logic            req_ok;
   logic            found;
   logic [BI_W-1:0] pick;
   logic            full;
   logic [BI_W-1:0] sel_blk;

   // execute-side signals
   blk_entry_type   tbl_eff, tbl_new;
   logic            tbl_we, mark_we, mark_wd, link_we;
   logic [ADDR_W-1:0] mark_waddr;
   logic [SI_W-1:0] slot_sel;
   logic            room_new;

   assign req     = req_word_type'(req_tdata);
   assign req_blk = BI_W'(req.blk_idx);
   assign req_ok  = (32'(req.blk_idx) < 32'(open_ff)) &&
                    (32'(req.slot_index) < SLOTS_PER_BLOCK);
   assign full    = (open_ff == CNT_W'(MAX_BLOCKS));

   // newest open block with room wins
   always_comb begin
      found = 1'b0;
      pick  = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         if (room_ff[i] && (i < int'(open_ff))) begin
            found = 1'b1;
            pick  = BI_W'(i);
         end
      end
   end

   assign sel_blk = found ? pick : open_ff[BI_W-1:0];

   // a freshly opened block starts empty whatever its table entry holds
   assign tbl_eff = new_ff ? '0 : tbl_q_ff;

   always_comb begin
      tbl_new    = tbl_eff;
      tbl_we     = 1'b0;
      mark_we    = 1'b0;
      mark_wd    = 1'b0;
      mark_waddr = addr_ff;
      link_we    = 1'b0;
      slot_sel   = tbl_eff.head;
      rsp_in           = '0;
      rsp_in.out_block = echo_blk_ff;
      rsp_in.out_slot  = echo_slot_ff;
      rsp_in.status    = STAT_OK;
      unique case (op_ff)
         OP_ALLOC: begin
            if (oom_ff) begin
               rsp_in.out_block = '0;
               rsp_in.out_slot  = '0;
               rsp_in.status    = STAT_OOM;
            end else begin
               if (tbl_eff.count != '0) begin
                  slot_sel      = tbl_eff.head;
                  tbl_new.head  = link_q_ff;
                  tbl_new.count = tbl_eff.count - PTR_W'(1);
               end else begin
                  slot_sel     = SI_W'(tbl_eff.bump);
                  tbl_new.bump = tbl_eff.bump + PTR_W'(1);
               end
               tbl_we     = 1'b1;
               mark_we    = 1'b1;
               mark_wd    = 1'b1;
               mark_waddr = addr_of(blk_ff, 32'(slot_sel));
               rsp_in.out_block = BLK_FW'(blk_ff);
               rsp_in.out_slot  = SLOT_FW'(slot_sel);
            end
         end
         OP_FREE: begin
            if (!ok_ff || !mark_q_ff) begin
               rsp_in.status = STAT_BAD_FREE;
            end else begin
               mark_we = 1'b1;
               tbl_we  = 1'b1;
               // top of the bump region just shrinks the region
               if ((tbl_eff.bump != '0) &&
                   (32'(echo_slot_ff) == 32'(tbl_eff.bump) - 32'd1)) begin
                  tbl_new.bump = tbl_eff.bump - PTR_W'(1);
               end else begin
                  link_we       = 1'b1;
                  tbl_new.head  = SI_W'(echo_slot_ff);
                  tbl_new.count = tbl_eff.count + PTR_W'(1);
               end
            end
         end
         OP_QUERY: begin
            rsp_in.is_marked = ok_ff & mark_q_ff;
         end
         OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   assign room_new = (tbl_new.count != '0) || (32'(tbl_new.bump) < SLOTS_PER_BLOCK);

   // control state next values
   always_comb begin
      open_in      = open_ff;
      room_in      = room_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.clear_step) begin
         clr_in = clr_ff + ADDR_W'(1);
      end
      if (cmd.finish && tbl_we) begin
         room_in[blk_ff] = room_new;
      end
      if (cmd.finish && (op_ff == OP_ALLOC) && new_ff && !oom_ff) begin
         open_in = open_ff + CNT_W'(1);
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= '0;
         room_ff      <= '1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         open_ff      <= open_in;
         room_ff      <= room_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff        <= req.op;
         echo_blk_ff  <= req.blk_idx;
         echo_slot_ff <= req.slot_index;
         blk_ff       <= (req.op == OP_ALLOC) ? sel_blk : req_blk;
         // only an allocate opens a block
         new_ff       <= (req.op == OP_ALLOC) && !found;
         oom_ff       <= !found && full;
         ok_ff        <= req_ok;
         addr_ff      <= addr_of(req_blk, 32'(req.slot_index));
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   // block table
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         tbl_q_ff <= tbl_mem[(req.op == OP_ALLOC) ? sel_blk : req_blk];
      end
      if (cmd.finish && tbl_we) begin
         tbl_mem[blk_ff] <= tbl_new;
      end
   end

   // free-list links
   always_ff @(posedge clock) begin
      if (cmd.link_read) begin
         link_q_ff <= link_mem[addr_of(blk_ff, 32'(tbl_eff.head))];
      end
      if (cmd.finish && link_we) begin
         link_mem[addr_ff] <= tbl_eff.head;
      end
   end

   // allocated marks
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mark_q_ff <= mark_mem[addr_of(req_blk, 32'(req.slot_index))];
      end
      if (cmd.clear_step) begin
         mark_mem[clr_ff] <= 1'b0;
      end else if (cmd.finish && mark_we) begin
         mark_mem[mark_waddr] <= mark_wd;
      end
   end

   assign stat.clear_last = (clr_ff == ADDR_W'(TOTAL - 1));
   assign stat.need_link  = (op_ff == OP_ALLOC) && !oom_ff && (tbl_eff.count != '0);
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

// ===== sv/block_slot_allocator.sv =====
// fixed-size slot allocator over MAX_BLOCKS blocks of SLOTS_PER_BLOCK slots.
// each request word carries op (0 allocate, 1 free, 2 query, 3 ignored), a
// block and a slot; each gives exactly one response word. allocate takes
// the newest open block with room (a room bitmap and a priority encoder
// pick it), pops that block's free list or else bumps its pointer, and
// opens a new block when none has room; status 1 means out of memory.
// free of the slot right below the bump pointer lowers the pointer, any
// other legal free pushes the slot onto the free list; an illegal free
// answers status 2 and changes nothing. query answers is_marked.
// one item at a time: accept, then execute with the registered block
// table and mark reads; an allocate that pops a free list adds a link
// fetch after execute, since the link memory read depends on the head
// read from the block table. a stalled response only holds off the
// execute step; the next word is still taken while a response waits.
// after reset the allocated marks are cleared one entry per cycle, and
// req_tready stays low until all MAX_BLOCKS * SLOTS_PER_BLOCK entries
// (4096 with the defaults) are clear.
module block_slot_allocator import bsa_pkg::*; #(
   parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS,
   parameter int SLOTS_PER_BLOCK = DEF_SLOTS_PER_BLOCK
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // op[1:0], blk_idx[5:2], slot_index[13:6]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // out_block[3:0], out_slot[11:4], status[13:12],
                                         // is_marked[14]
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   // sequencer: clearing pass, accept, execute, link fetch
   bsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // tables, memories and the response register
   bsa_datapath #(
      .MAX_BLOCKS      (MAX_BLOCKS),
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== sv/bsa_checker.sv =====
`include "assert_macros.svh"

module bsa_checker import bsa_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   rsp_word_type rsp;
   assign rsp = rsp_word_type'(rsp_tdata);

   property p_rsp_hold;
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty

   property p_oom_zero;
      rsp_tvalid && (rsp.status == STAT_OOM) |->
         (rsp.out_block == '0) && (rsp.out_slot == '0) && !rsp.is_marked;
   endproperty

   property p_mark_ok;
      rsp_tvalid && rsp.is_marked |-> rsp.status == STAT_OK;
   endproperty

   property p_reset_quiet;
      reset |=> !req_tready && !rsp_tvalid;
   endproperty

   // a waiting response word stays put
   `ASSERT_CLK(a_rsp_hold, clock, reset, p_rsp_hold, "response changed while stalled")

   // out of memory reports an all-zero location
   `ASSERT_CLK(a_oom_zero, clock, reset, p_oom_zero, "out of memory with nonzero location")

   // a set mark only comes with an ok status
   `ASSERT_CLK(a_mark_ok, clock, reset, p_mark_ok, "marked answer with error status")

   // clearing pass follows reset: nothing taken, nothing shown
   `ASSERT_CLK_ALWAYS(a_reset_quiet, clock, p_reset_quiet, "busy right after reset")

endmodule

bind block_slot_allocator bsa_checker u_bsa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/tb.sv =====
module tb import bsa_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NB = DEF_MAX_BLOCKS;
   localparam int NS = DEF_SLOTS_PER_BLOCK;

   // mirror of the allocator tables plus the queue of responses still owed
   class slot_ledger;
      int           blocks_open;
      int           bump_end[NB];
      int           free_count[NB];
      bit [7:0]     free_head[NB];
      bit [7:0]     next_link[NB*NS];
      bit           alloc_mark[NB*NS];
      int           live[$];          // flat index of every allocated slot
      int           live_pos[NB*NS];  // position of each slot in live
      rsp_word_type awaited[$];
      int           errors;
      int           n_checked;
      int           n_alloc;
      int           n_oom;
      int           n_free;
      int           n_bad_free;
      int           n_query;
      int           n_marked;

      function void live_add(int idx);
         live_pos[idx] = live.size();
         live.insert(live.size(), idx);
      endfunction

      function void live_drop(int idx);
         int p;
         int last;
         p = live_pos[idx];
         last = live[live.size()-1];
         live[p] = last;
         live_pos[last] = p;
         void'(live.pop_back());
      endfunction

      // one request against the mirrored tables, returns the response owed
      function rsp_word_type allocator_step(req_word_type w);
         rsp_word_type r;
         int           blk;
         int           slot;
         int           idx;
         bit           found;
         r = '0;
         r.out_block = w.blk_idx;
         r.out_slot  = w.slot_index;
         r.status    = STAT_OK;
         blk   = w.blk_idx;
         slot  = w.slot_index;
         idx   = blk * NS + slot;
         found = 1'b0;
         case (w.op)
            OP_ALLOC: begin
               // newest open block with room wins
               for (int i = blocks_open - 1; i >= 0; i--) begin
                  if (!found && (free_count[i] != 0 || bump_end[i] < NS)) begin
                     blk = i;
                     found = 1'b1;
                  end
               end
               if (!found && blocks_open >= NB) begin
                  r.out_block = '0;
                  r.out_slot  = '0;
                  r.status    = STAT_OOM;
                  n_oom++;
                  return r;
               end
               if (!found) begin
                  blk = blocks_open;
                  blocks_open++;
                  bump_end[blk]   = 0;
                  free_count[blk] = 0;
               end
               if (free_count[blk] != 0) begin
                  slot = free_head[blk];
                  free_head[blk] = next_link[blk*NS + slot];
                  free_count[blk]--;
               end else begin
                  slot = bump_end[blk];
                  bump_end[blk]++;
               end
               idx = blk * NS + slot;
               alloc_mark[idx] = 1'b1;
               live_add(idx);
               r.out_block = 4'(blk);
               r.out_slot  = 8'(slot);
               n_alloc++;
            end
            OP_FREE: begin
               if (blk >= blocks_open || slot >= NS || !alloc_mark[idx]) begin
                  r.status = STAT_BAD_FREE;
                  n_bad_free++;
               end else begin
                  alloc_mark[idx] = 1'b0;
                  live_drop(idx);
                  if (bump_end[blk] != 0 && slot == bump_end[blk] - 1) begin
                     bump_end[blk]--;
                  end else begin
                     next_link[idx]  = free_head[blk];
                     free_head[blk]  = 8'(slot);
                     free_count[blk]++;
                  end
                  n_free++;
               end
            end
            OP_QUERY: begin
               if (blk < blocks_open && slot < NS) begin
                  r.is_marked = alloc_mark[idx];
               end
               n_query++;
               if (r.is_marked) n_marked++;
            end
            default: begin
            end
         endcase
         return r;
      endfunction

      function void note_request(req_word_type w);
         awaited.insert(awaited.size(), allocator_step(w));
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type exp;
         n_checked++;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: stray response: blk %0d slot %0d st %0d mk %0d",
                        $realtime, got.out_block, got.out_slot, got.status, got.is_marked);
            end
            return;
         end
         exp = awaited.pop_front();
         if (got.out_block !== exp.out_block || got.out_slot !== exp.out_slot ||
             got.status !== exp.status || got.is_marked !== exp.is_marked) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: mismatch: exp %0d/%0d st %0d mk %0d, got %0d/%0d st %0d mk %0d",
                        $realtime, exp.out_block, exp.out_slot, exp.status, exp.is_marked,
                        got.out_block, got.out_slot, got.status, got.is_marked);
            end
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   slot_ledger sb;
   bit         req_calm = 1'b0;   // no gaps between request words while set
   bit         rsp_calm = 1'b0;   // no stalls on the response side while set
   int         req_count = 0;

   block_slot_allocator #(
      .MAX_BLOCKS     (NB),
      .SLOTS_PER_BLOCK(NS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic req_word_type make_req(op_type op, int blk, int slot);
      req_word_type w;
      w = '0;
      w.op         = op;
      w.blk_idx    = 4'(blk);
      w.slot_index = 8'(slot);
      return w;
   endfunction

   // random request: mostly legal traffic on live slots, some noise
   function automatic req_word_type draw_request(int alloc_pct);
      req_word_type w;
      int           r;
      int           idx;
      int           blk;
      w = make_req(OP_ALLOC, $urandom_range(0, NB-1), $urandom_range(0, NS-1));
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
         w.op = OP_ALLOC;
      end else if (r < alloc_pct + 30 && sb.live.size() != 0) begin
         w.op = OP_FREE;
         idx = sb.live[$urandom_range(0, sb.live.size()-1)];
         w.blk_idx    = 4'(idx / NS);
         w.slot_index = 8'(idx % NS);
         // now and then free the top of a block so the bump pointer drops
         if ($urandom_range(0, 3) == 0 && sb.blocks_open > 0) begin
            blk = $urandom_range(0, sb.blocks_open-1);
            if (sb.bump_end[blk] > 0) begin
               w.blk_idx    = 4'(blk);
               w.slot_index = 8'(sb.bump_end[blk] - 1);
            end
         end
      end else if (r < alloc_pct + 45) begin
         w.op = OP_QUERY;
         if (sb.live.size() != 0 && $urandom_range(0, 1) == 1) begin
            idx = sb.live[$urandom_range(0, sb.live.size()-1)];
            w.blk_idx    = 4'(idx / NS);
            w.slot_index = 8'(idx % NS);
         end
      end else if (r < alloc_pct + 55) begin
         // free at a random spot, mostly rejected
         w.op = OP_FREE;
      end else begin
         w.op = op_type'($urandom_range(0, 3));
      end
      return w;
   endfunction

   // one request word, with a random gap in front unless in a calm stretch
   task automatic send_request(req_word_type w);
      int gap;
      if (req_count % 50 == 0) req_calm = ($urandom_range(0, 3) == 0);
      req_count++;
      gap = req_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      sb.note_request(w);
   endtask

   // response side: random stalls, check every word taken
   initial begin
      int stall;
      int n;
      n = 0;
      while (reset) @(posedge clock);
      forever begin
         if (n % 50 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
         n++;
         stall = rsp_calm ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_word_type'(rsp_tdata));
      end
   end

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, bump, lowering free, free list push/pop, bad frees
      send_request(make_req(OP_QUERY, 0, 0));
      send_request(make_req(OP_FREE, 0, 0));        // block not open yet
      send_request(make_req(OP_NONE, 15, 255));
      send_request(make_req(OP_ALLOC, 0, 0));
      send_request(make_req(OP_ALLOC, 15, 255));    // fields ignored on allocate
      send_request(make_req(OP_ALLOC, 0, 0));
      send_request(make_req(OP_QUERY, 0, 1));
      send_request(make_req(OP_FREE, 0, 2));        // top slot, pointer drops
      send_request(make_req(OP_FREE, 0, 0));        // goes on the free list
      send_request(make_req(OP_FREE, 0, 0));        // double free
      send_request(make_req(OP_FREE, 0, 200));      // above the bump pointer
      send_request(make_req(OP_ALLOC, 0, 0));       // pops slot 0
      send_request(make_req(OP_ALLOC, 0, 0));       // bumps again
      send_request(make_req(OP_FREE, 0, 1));
      send_request(make_req(OP_ALLOC, 0, 0));       // pops slot 1
      send_request(make_req(OP_QUERY, 15, 255));    // unopened block
      send_request(make_req(OP_FREE, 15, 255));
      send_request(make_req(OP_QUERY, 0, 255));     // opened block, slot never used
      send_request(make_req(OP_NONE, 0, 0));
      send_request(make_req(OP_QUERY, 1, 0));

      // mixed traffic with a slight lean toward growth
      repeat (1200) send_request(draw_request(45));

      // heavy allocation so further blocks open over deep free lists
      repeat (380) send_request(draw_request(80));
      req_tvalid <= 1'b0;

      // drain, then give the block time to show any stray word
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d allocations, %0d out-of-memory, %0d frees, %0d rejected frees",
               sb.n_alloc, sb.n_oom, sb.n_free, sb.n_bad_free);
      $display("covered %0d queries (%0d marked), %0d responses checked, %0d errors",
               sb.n_query, sb.n_marked, sb.n_checked, sb.errors);
      if (sb.errors == 0) begin
         $display("block_slot_allocator test passed");
      end else begin
         $display("block_slot_allocator test failed");
      end
      $finish;
   end

   // watchdog: covers the mark clearing after reset and a slow worst case
   initial begin
      #2_000_000;
      $display("block_slot_allocator test failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/bsa_pkg.sv
sv/bsa_ctrl.sv
sv/bsa_datapath.sv
sv/block_slot_allocator.sv
sv/bsa_checker.sv
bench/tb.sv
